// ===== src/lkv_pkg.sv =====
// Shared constants, types and state codes for the LRU key-value cache.
package lkv_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int KEY_BITS_DEF   = 16;
    localparam int VALUE_BITS_DEF = 32;

    localparam int KEY_W  = 16;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
    } lkv_req_t;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] data;
    } lkv_res_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SEARCH = 5'b00010,
        ST_SHIFT  = 5'b00100,
        ST_FRONT  = 5'b01000,
        ST_DONE   = 5'b10000
    } lkv_state_t;

endpackage

// ===== src/lkv_if.sv =====
// Request and response channel interfaces.
interface lkv_req_if import lkv_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic [KEY_W-1:0]         key;
    logic signed [DATA_W-1:0] data_in;

    modport source (output valid, cmd, key, data_in, input ready);
    modport sink (input valid, cmd, key, data_in, output ready);
endinterface

interface lkv_rsp_if import lkv_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     hit;
    logic signed [DATA_W-1:0] data_out;

    modport source (output valid, hit, data_out, input ready);
    modport sink (input valid, hit, data_out, output ready);
endinterface

// ===== src/lru_key_value_cache_unit.sv =====
// Top level of the LRU key-value cache: capacity register, sequencer, RAM, response register.
//
//  channel | dir | handshake        | payload
//  req     | in  | valid/ready      | cmd, key, data_in
//  rsp     | out | valid/ready      | hit, data_out
//  cfg     | in  | cfg_we, no wait  | cfg_data (capacity)
//
// A get miss searches all n occupied entries; a hit at position p searches up to p and moves
// the p entries in front of it; a put miss searches n entries and moves the k entries kept.
// The single RAM read port sets the pace: one entry searched or moved per cycle.
// Reset empties the cache at once and sets capacity to 16; no clearing pass.
// req is taken only while the sequencer is idle; a finished result waits in the sequencer
// while the response register is stalled.
module lru_key_value_cache_unit import lkv_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    lkv_req_if.sink          req,
    lkv_rsp_if.source        rsp,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_data
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W  = $clog2(DEPTH + 1);
    localparam int ENT_W  = KEY_BITS + VALUE_BITS;

    logic [CAP_W-1:0]  cap_reg;
    logic [OCC_W-1:0]  cap_eff;
    lkv_req_t          req_s;
    lkv_res_t          res_s;
    logic              res_valid;
    logic              res_take;
    logic              rsp_valid_reg;
    logic              rsp_hit_reg;
    logic [DATA_W-1:0] rsp_data_reg;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [ENT_W-1:0]  ram_wr_data;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [ENT_W-1:0]  ram_rd_data;

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = OCC_W'(1);
        end
        else if (int'(cap_reg) > DEPTH)
        begin
            cap_eff = OCC_W'(DEPTH);
        end
        else
        begin
            cap_eff = OCC_W'(cap_reg);
        end
    end

    assign req_s.cmd  = req.cmd;
    assign req_s.key  = req.key;
    assign req_s.data = $unsigned(req.data_in);
    assign res_take   = res_valid && (!rsp_valid_reg || rsp.ready);

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.hit      = rsp_hit_reg;
    assign rsp.data_out = $signed(rsp_data_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (res_take)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            rsp_hit_reg  <= res_s.hit;
            rsp_data_reg <= res_s.data;
        end
    end

    lkv_ctrl #(
        .DEPTH      (DEPTH),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .ADDR_W     (ADDR_W),
        .OCC_W      (OCC_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_ready   (req.ready),
        .req         (req_s),
        .cap_eff     (cap_eff),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res_s),
        .ram_we      (ram_we),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    lkv_ram #(
        .WIDTH  (ENT_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

// ===== src/lkv_ram.sv =====
// Generic simple dual-port RAM with registered read.
module lkv_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/lkv_ctrl.sv =====
// Sequencer: linear key search, entry shift and front write over one RAM.
module lkv_ctrl import lkv_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int OCC_W      = $clog2(DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  lkv_req_t                      req,
    input  logic [OCC_W-1:0]              cap_eff,
    output logic                          res_valid,
    input  logic                          res_take,
    output lkv_res_t                      res,
    output logic                          ram_we,
    output logic [ADDR_W-1:0]             ram_wr_addr,
    output logic [KEY_BITS+VALUE_BITS-1:0] ram_wr_data,
    output logic [ADDR_W-1:0]             ram_rd_addr,
    input  logic [KEY_BITS+VALUE_BITS-1:0] ram_rd_data
);

    localparam int ENT_W = KEY_BITS + VALUE_BITS;

    lkv_state_t             state_reg, state_next;
    logic [OCC_W-1:0]       occ_reg, occ_next;
    logic [OCC_W-1:0]       idx_reg, idx_next;
    logic                   pend_reg, pend_next;
    logic [ADDR_W-1:0]      pend_idx_reg, pend_idx_next;
    logic [OCC_W-1:0]       sh_reg, sh_next;
    logic                   wpend_reg, wpend_next;
    logic [ADDR_W-1:0]      wdst_reg, wdst_next;
    logic                   put_reg, put_next;
    logic                   hit_reg, hit_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [VALUE_BITS-1:0]  val_reg, val_next;
    logic [KEY_BITS-1:0]    rd_key;
    logic [VALUE_BITS-1:0]  rd_val;
    logic                   match;
    logic [OCC_W-1:0]       keep_cnt;

    assign rd_key    = ram_rd_data[ENT_W-1 -: KEY_BITS];
    assign rd_val    = ram_rd_data[VALUE_BITS-1:0];
    assign match     = pend_reg && (rd_key == key_reg);
    assign keep_cnt  = (occ_reg >= cap_eff) ? cap_eff - OCC_W'(1) : occ_reg;
    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res.hit   = hit_reg;
    assign res.data  = (hit_reg && !put_reg) ? DATA_W'(val_reg) : '0;

    always_comb
    begin
        state_next    = state_reg;
        occ_next      = occ_reg;
        idx_next      = idx_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        sh_next       = sh_reg;
        wpend_next    = 1'b0;
        wdst_next     = wdst_reg;
        put_next      = put_reg;
        hit_next      = hit_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        ram_rd_addr   = idx_reg[ADDR_W-1:0];
        ram_we        = 1'b0;
        ram_wr_addr   = wdst_reg;
        ram_wr_data   = ram_rd_data;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    put_next   = (req.cmd == CMD_PUT);
                    key_next   = KEY_BITS'(req.key);
                    val_next   = VALUE_BITS'(req.data);
                    idx_next   = '0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (match)
                begin
                    hit_next   = 1'b1;
                    if (!put_reg)
                    begin
                        val_next = rd_val;
                    end
                    sh_next    = OCC_W'(pend_idx_reg);
                    state_next = ST_SHIFT;
                end
                else if (idx_reg < occ_reg)
                begin
                    ram_rd_addr   = idx_reg[ADDR_W-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[ADDR_W-1:0];
                    idx_next      = idx_reg + OCC_W'(1);
                end
                else
                begin
                    hit_next = 1'b0;
                    if (put_reg)
                    begin
                        sh_next    = keep_cnt;
                        occ_next   = keep_cnt + OCC_W'(1);
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SHIFT:
            begin
                if (wpend_reg)
                begin
                    ram_we      = 1'b1;
                    ram_wr_addr = wdst_reg;
                    ram_wr_data = ram_rd_data;
                end
                if (sh_reg != '0)
                begin
                    ram_rd_addr = ADDR_W'(sh_reg - OCC_W'(1));
                    wpend_next  = 1'b1;
                    wdst_next   = sh_reg[ADDR_W-1:0];
                    sh_next     = sh_reg - OCC_W'(1);
                end
                else if (!wpend_reg)
                begin
                    state_next = ST_FRONT;
                end
            end
            ST_FRONT:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = '0;
                ram_wr_data = {key_reg, val_reg};
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            occ_reg   <= '0;
            pend_reg  <= 1'b0;
            wpend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            pend_reg  <= pend_next;
            wpend_reg <= wpend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
        sh_reg       <= sh_next;
        wdst_reg     <= wdst_next;
        put_reg      <= put_next;
        hit_reg      <= hit_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
    end

endmodule

// ===== src/lkv_checker.sv =====
// Port-level assertions for the LRU key-value cache, bound to the top level.
module lkv_checker import lkv_pkg::*; (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     req_valid,
    input logic                     req_ready,
    input logic                     rsp_valid,
    input logic                     rsp_ready,
    input logic                     rsp_hit,
    input logic signed [DATA_W-1:0] rsp_data
);

    logic [1:0] open_reg;
    logic       req_acc;
    logic       rsp_acc;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_reg + 2'(req_acc) - 2'(rsp_acc);
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> !req_ready)
        else $error("request taken while a transaction is in progress");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_data))
        else $error("stalled response changed");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_hit |-> rsp_data == '0)
        else $error("miss response carries data");

    a_rsp_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> open_reg != 2'd0)
        else $error("response without a request");

    a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg != 2'd3)
        else $error("too many transactions in flight");

endmodule

bind lru_key_value_cache_unit lkv_checker u_lkv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_hit   (rsp.hit),
    .rsp_data  (rsp.data_out)
);
